### hw/rtl/fuds_pkg.sv
// ----------------------------------------------------------------------------
// fuds_pkg
// Types, character codes and helpers shared by the form body decoder.
// ----------------------------------------------------------------------------
package fuds_pkg;

    localparam int unsigned MAX_RES = 5;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    typedef enum logic [1:0] {
        KIND_KEY       = 2'd0,
        KIND_VALUE     = 2'd1,
        KIND_FIELD_END = 2'd2,
        KIND_BODY_END  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_PCT  = 2'd1,
        PEND_HI   = 2'd2
    } t_pend;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       has_equals;
        logic       run_last;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0]     n;
        t_res [MAX_RES-1:0]   res;
    } t_burst;

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h61 + HEX_TEN;
            return {1'b1, d[3:0]};
        end
        if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h41 + HEX_TEN;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

### hw/rtl/fuds_if.sv
// ----------------------------------------------------------------------------
// fuds_if
// Valid/ready channels for body bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface fuds_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] in_byte;
    logic       body_last;

    modport source (output valid, has_byte, in_byte, body_last, input ready);
    modport sink   (input valid, has_byte, in_byte, body_last, output ready);
endinterface

interface fuds_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       has_equals;
    logic       run_last;

    modport source (output valid, kind, data_byte, has_equals, run_last, input ready);
    modport sink   (input valid, kind, data_byte, has_equals, run_last, output ready);
endinterface

### hw/rtl/fuds_decode.sv
// ----------------------------------------------------------------------------
// fuds_decode
// Input register, parse state and the single-pass decode of one beat into a
// burst of up to five results.
// ----------------------------------------------------------------------------
module fuds_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fuds_in_if.sink             i_in,
    input  logic                i_free,
    output logic                o_load,
    output fuds_pkg::t_burst    o_burst
);

    logic                r_in_valid;
    logic                r_has_byte;
    logic [7:0]          r_in_byte;
    logic                r_body_last;

    fuds_pkg::t_pend     r_pend_cnt, n_pend_cnt;
    logic [7:0]          r_pend_hi,  n_pend_hi;
    logic                r_in_value, n_in_value;
    logic                r_field_ne, n_field_ne;

    logic [fuds_pkg::CNT_W-1:0] n_idx;
    fuds_pkg::t_burst    n_burst;
    logic [4:0]          c_hex;
    logic [4:0]          c_hex_hi;
    logic                c_is_amp;
    logic                c_is_sep;

    assign o_load     = r_in_valid & i_free;
    assign i_in.ready = ~r_in_valid | o_load;
    assign o_burst    = n_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_has_byte  <= i_in.has_byte;
            r_in_byte   <= i_in.in_byte;
            r_body_last <= i_in.body_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= fuds_pkg::PEND_NONE;
            r_pend_hi  <= 8'h00;
            r_in_value <= 1'b0;
            r_field_ne <= 1'b0;
        end else if (o_load) begin
            r_pend_cnt <= n_pend_cnt;
            r_pend_hi  <= n_pend_hi;
            r_in_value <= n_in_value;
            r_field_ne <= n_field_ne;
        end
    end

    assign c_hex    = fuds_pkg::hex_val(r_in_byte);
    assign c_hex_hi = fuds_pkg::hex_val(r_pend_hi);
    assign c_is_amp = (r_in_byte == fuds_pkg::CH_AMP);
    assign c_is_sep = (r_in_byte == fuds_pkg::CH_EQ) && !r_in_value;

    always_comb begin
        n_pend_cnt = r_pend_cnt;
        n_pend_hi  = r_pend_hi;
        n_in_value = r_in_value;
        n_field_ne = r_field_ne;
        n_burst    = '0;
        n_idx      = '0;

        if (r_has_byte) begin
            // held escape goes out raw
            if (c_is_amp || c_is_sep ||
                (n_pend_cnt != fuds_pkg::PEND_NONE && !c_hex[4])) begin
                if (n_pend_cnt != fuds_pkg::PEND_NONE) begin
                    n_burst.res[n_idx] = '{n_in_value ? fuds_pkg::KIND_VALUE
                                                      : fuds_pkg::KIND_KEY,
                                           fuds_pkg::CH_PCT, 1'b0, 1'b0};
                    n_idx = n_idx + 1'b1;
                end
                if (n_pend_cnt == fuds_pkg::PEND_HI) begin
                    n_burst.res[n_idx] = '{n_in_value ? fuds_pkg::KIND_VALUE
                                                      : fuds_pkg::KIND_KEY,
                                           n_pend_hi, 1'b0, 1'b0};
                    n_idx = n_idx + 1'b1;
                end
                n_pend_cnt = fuds_pkg::PEND_NONE;
                n_pend_hi  = 8'h00;
            end

            if (c_is_amp) begin
                if (n_field_ne || n_in_value) begin
                    n_burst.res[n_idx] = '{fuds_pkg::KIND_FIELD_END, 8'h00,
                                           n_in_value, 1'b0};
                    n_idx = n_idx + 1'b1;
                end
                n_in_value = 1'b0;
                n_field_ne = 1'b0;
            end else if (c_is_sep) begin
                n_in_value = 1'b1;
            end else begin
                if (!n_in_value) begin
                    n_field_ne = 1'b1;
                end
                case (n_pend_cnt)
                    fuds_pkg::PEND_PCT: begin
                        n_pend_hi  = r_in_byte;
                        n_pend_cnt = fuds_pkg::PEND_HI;
                    end
                    fuds_pkg::PEND_HI: begin
                        n_burst.res[n_idx] = '{n_in_value ? fuds_pkg::KIND_VALUE
                                                          : fuds_pkg::KIND_KEY,
                                               {c_hex_hi[3:0], c_hex[3:0]}, 1'b0, 1'b0};
                        n_idx      = n_idx + 1'b1;
                        n_pend_cnt = fuds_pkg::PEND_NONE;
                        n_pend_hi  = 8'h00;
                    end
                    default: begin
                        if (r_in_byte == fuds_pkg::CH_PCT) begin
                            n_pend_cnt = fuds_pkg::PEND_PCT;
                        end else begin
                            n_burst.res[n_idx] = '{n_in_value ? fuds_pkg::KIND_VALUE
                                                              : fuds_pkg::KIND_KEY,
                                                   (r_in_byte == fuds_pkg::CH_PLUS)
                                                       ? fuds_pkg::CH_SPACE : r_in_byte,
                                                   1'b0, 1'b0};
                            n_idx = n_idx + 1'b1;
                        end
                    end
                endcase
            end
        end

        if (r_body_last) begin
            if (n_pend_cnt != fuds_pkg::PEND_NONE) begin
                n_burst.res[n_idx] = '{n_in_value ? fuds_pkg::KIND_VALUE
                                                  : fuds_pkg::KIND_KEY,
                                       fuds_pkg::CH_PCT, 1'b0, 1'b0};
                n_idx = n_idx + 1'b1;
            end
            if (n_pend_cnt == fuds_pkg::PEND_HI) begin
                n_burst.res[n_idx] = '{n_in_value ? fuds_pkg::KIND_VALUE
                                                  : fuds_pkg::KIND_KEY,
                                       n_pend_hi, 1'b0, 1'b0};
                n_idx = n_idx + 1'b1;
            end
            if (n_field_ne || n_in_value) begin
                n_burst.res[n_idx] = '{fuds_pkg::KIND_FIELD_END, 8'h00,
                                       n_in_value, 1'b0};
                n_idx = n_idx + 1'b1;
            end
            n_burst.res[n_idx] = '{fuds_pkg::KIND_BODY_END, 8'h00, 1'b0, 1'b0};
            n_idx      = n_idx + 1'b1;
            n_pend_cnt = fuds_pkg::PEND_NONE;
            n_pend_hi  = 8'h00;
            n_in_value = 1'b0;
            n_field_ne = 1'b0;
        end

        if (n_idx != '0) begin
            n_burst.res[n_idx - 1'b1].run_last = 1'b1;
        end
        n_burst.n = n_idx;
    end

endmodule

### hw/rtl/fuds_outbuf.sv
// ----------------------------------------------------------------------------
// fuds_outbuf
// Result register holding one burst, sent one beat per cycle while ready.
// ----------------------------------------------------------------------------
module fuds_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  fuds_pkg::t_burst    i_burst,
    output logic                o_free,
    fuds_out_if.source          o_out
);

    fuds_pkg::t_res [fuds_pkg::MAX_RES-1:0] r_res;
    logic [fuds_pkg::CNT_W-1:0]             r_left;
    logic [fuds_pkg::CNT_W-1:0]             r_rd;
    logic                                   c_drain;
    fuds_pkg::t_res                         c_head;

    assign c_drain = o_out.valid & o_out.ready;
    assign o_free  = (r_left == '0) || (c_drain && r_left == fuds_pkg::CNT_W'(1));
    assign c_head  = r_res[r_rd];

    assign o_out.valid      = (r_left != '0);
    assign o_out.kind       = c_head.kind;
    assign o_out.data_byte  = c_head.data_byte;
    assign o_out.has_equals = c_head.has_equals;
    assign o_out.run_last   = c_head.run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_rd   <= '0;
        end else if (i_load) begin
            r_left <= i_burst.n;
            r_rd   <= '0;
        end else if (c_drain) begin
            r_left <= r_left - 1'b1;
            r_rd   <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_burst.res;
        end
    end

endmodule

### hw/rtl/form_urlencoded_stream_decoder.sv
// ----------------------------------------------------------------------------
// form_urlencoded_stream_decoder
// Streaming form-urlencoded body decoder: keys, values, field and body ends.
// ----------------------------------------------------------------------------
// One body byte per beat goes in; decoded key and value bytes, field-end and
// body-end markers come out, one per beat, with run_last on the final result
// of each input beat. While the result channel is ready, a beat that gives
// zero or one result is taken every cycle; a beat that gives more (up to five,
// e.g. a broken escape at the end of the body) holds the input while the
// result register sends them at one result per cycle. Each input beat passes
// through the input register, then the result register.
// ----------------------------------------------------------------------------
module form_urlencoded_stream_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fuds_in_if.sink      i_in,
    fuds_out_if.source   o_out
);

    logic                c_load;
    logic                c_free;
    fuds_pkg::t_burst    c_burst;

    fuds_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_free  (c_free),
        .o_load  (c_load),
        .o_burst (c_burst)
    );

    fuds_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (c_load),
        .i_burst (c_burst),
        .o_free  (c_free),
        .o_out   (o_out)
    );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming form body decoder.
// ----------------------------------------------------------------------------
// Body bytes are pushed through the input channel with random gaps while the
// result channel applies random back-pressure, save in a last steady phase.
// Every accepted input beat is run through a local model of the decoder (escape
// tracking, key/value part, field and body ends) and the results it should give
// are queued. Each result beat is checked field by field against the oldest
// queued entry. Directed bodies exercise the escape and separator corner cases,
// then random bodies of mostly well-formed tokens, noise and broken escapes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;

    fuds_in_if  in_ch ();
    fuds_out_if out_ch ();

    form_urlencoded_stream_decoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // decoder model state
    fuds_pkg::t_pend esc_state   = fuds_pkg::PEND_NONE;
    logic [7:0]      esc_hi_char = 8'h00;
    logic            in_value    = 1'b0;
    logic            key_seen    = 1'b0;

    fuds_pkg::t_res beat_results[$];
    fuds_pkg::t_res expected_results[$];

    bit steady = 1'b0;
    int mismatches = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int bodies_done = 0;
    int cycle_count = 0;

    string hex_chars = "0123456789abcdefABCDEF";

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function void emit_result(input fuds_pkg::t_kind k, input logic [7:0] d,
                              input logic eq);
        fuds_pkg::t_res r;
        r.kind       = k;
        r.data_byte  = d;
        r.has_equals = eq;
        r.run_last   = 1'b0;
        beat_results = {beat_results, r};
    endfunction

    function void emit_decoded(input logic [7:0] d);
        emit_result(in_value ? fuds_pkg::KIND_VALUE : fuds_pkg::KIND_KEY, d, 1'b0);
    endfunction

    function void flush_escape();
        if (esc_state != fuds_pkg::PEND_NONE) emit_decoded(fuds_pkg::CH_PCT);
        if (esc_state == fuds_pkg::PEND_HI) emit_decoded(esc_hi_char);
        esc_state   = fuds_pkg::PEND_NONE;
        esc_hi_char = 8'h00;
    endfunction

    function void decode_part_byte(input logic [7:0] c);
        int lo;
        int hi;
        if (esc_state == fuds_pkg::PEND_PCT) begin
            if (hex_nibble(c) >= 0) begin
                esc_hi_char = c;
                esc_state   = fuds_pkg::PEND_HI;
                return;
            end
            flush_escape();
        end else if (esc_state == fuds_pkg::PEND_HI) begin
            lo = hex_nibble(c);
            if (lo >= 0) begin
                hi          = hex_nibble(esc_hi_char);
                esc_state   = fuds_pkg::PEND_NONE;
                esc_hi_char = 8'h00;
                emit_decoded(8'((hi << 4) | lo));
                return;
            end
            flush_escape();
        end
        if (c == fuds_pkg::CH_PCT) begin
            esc_state = fuds_pkg::PEND_PCT;
        end else if (c == fuds_pkg::CH_PLUS) begin
            emit_decoded(fuds_pkg::CH_SPACE);
        end else begin
            emit_decoded(c);
        end
    endfunction

    function void close_field();
        flush_escape();
        if (key_seen || in_value) emit_result(fuds_pkg::KIND_FIELD_END, 8'h00, in_value);
        in_value = 1'b0;
        key_seen = 1'b0;
    endfunction

    function void predict_beat(input logic hb, input logic [7:0] c, input logic last);
        beat_results.delete();
        if (hb) begin
            if (c == fuds_pkg::CH_AMP) begin
                close_field();
            end else if (c == fuds_pkg::CH_EQ && !in_value) begin
                flush_escape();
                in_value = 1'b1;
            end else begin
                if (!in_value) key_seen = 1'b1;
                decode_part_byte(c);
            end
        end
        if (last) begin
            close_field();
            emit_result(fuds_pkg::KIND_BODY_END, 8'h00, 1'b0);
            esc_state   = fuds_pkg::PEND_NONE;
            esc_hi_char = 8'h00;
            in_value    = 1'b0;
            key_seen    = 1'b0;
            bodies_done++;
        end
        if (beat_results.size() > 0) beat_results[beat_results.size() - 1].run_last = 1'b1;
        foreach (beat_results[i]) expected_results = {expected_results, beat_results[i]};
    endfunction

    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 38);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic send_beat(input logic hb, input logic [7:0] c, input logic last);
        while (take_gap()) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.has_byte  <= hb;
        in_ch.in_byte   <= c;
        in_ch.body_last <= last;
        do @(posedge clk); while (!in_ch.ready);
        predict_beat(hb, c, last);
        if (hb || last) beats_sent++;
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            send_beat(1'b1, s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] plain_char();
        case ($urandom_range(0, 2))
            0:       return 8'("a" + $urandom_range(0, 25));
            1:       return 8'("A" + $urandom_range(0, 25));
            default: return 8'("0" + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] hex_char();
        return hex_chars[$urandom_range(0, 21)];
    endfunction

    // result beat checker
    always @(posedge clk) begin
        fuds_pkg::t_res want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d data %02h",
                                          out_ch.kind, out_ch.data_byte));
            end else begin
                want = expected_results.pop_front();
                if (out_ch.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, want.kind));
                if (out_ch.data_byte !== want.data_byte)
                    report_mismatch($sformatf("data_byte %02h, want %02h",
                                              out_ch.data_byte, want.data_byte));
                if (out_ch.has_equals !== want.has_equals)
                    report_mismatch($sformatf("has_equals %b, want %b",
                                              out_ch.has_equals, want.has_equals));
                if (out_ch.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                                              out_ch.run_last, want.run_last));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 38);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // key with escapes and a plus, later equals, empty field, bare equals field
    task automatic test_field_structure();
        send_text("%4a+=%Fz=%&&=", 1'b0);
        send_beat(1'b0, 8'h00, 1'b0);
        send_beat(1'b0, 8'hFF, 1'b1);
    endtask

    // byte extremes, doubled percent, decode at part end, broken escape at body end
    task automatic test_escape_breaks();
        send_beat(1'b1, 8'h00, 1'b0);
        send_beat(1'b1, 8'hFF, 1'b0);
        send_text("=%%C9&%4", 1'b0);
        send_beat(1'b1, "z", 1'b1);
    endtask

    task automatic test_random_bodies(input int n_beats, input bit no_gaps);
        int target;
        int r;
        steady = no_gaps;
        target = beats_sent + n_beats;
        while (beats_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 36) begin
                send_beat(1'b1, plain_char(), 1'b0);
            end else if (r < 50) begin
                send_beat(1'b1, fuds_pkg::CH_PCT, 1'b0);
                send_beat(1'b1, hex_char(), 1'b0);
                send_beat(1'b1, hex_char(), 1'b0);
            end else if (r < 56) begin
                send_beat(1'b1, fuds_pkg::CH_PCT, 1'b0);
                if ($urandom_range(0, 1)) send_beat(1'b1, hex_char(), 1'b0);
                send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0);
            end else if (r < 63) begin
                send_beat(1'b1, fuds_pkg::CH_PLUS, 1'b0);
            end else if (r < 72) begin
                send_beat(1'b1, fuds_pkg::CH_EQ, 1'b0);
            end else if (r < 81) begin
                send_beat(1'b1, fuds_pkg::CH_AMP, 1'b0);
            end else if (r < 88) begin
                send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0);
            end else if (r < 93) begin
                send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            end else if (r < 97) begin
                send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end else begin
                send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.has_byte  <= 1'b0;
        in_ch.in_byte   <= 8'h00;
        in_ch.body_last <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_field_structure();
        test_escape_breaks();
        test_random_bodies(140, 1'b0);
        test_random_bodies(50, 1'b1);
        in_ch.valid <= 1'b0;

        while (expected_results.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input beats over %0d bodies, %0d results checked",
                 beats_sent, bodies_done, results_checked);
        $display("escapes, separators, empty fields and body ends under random stalls");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### form_urlencoded_stream_decoder.f
hw/rtl/fuds_pkg.sv
hw/rtl/fuds_if.sv
hw/rtl/fuds_decode.sv
hw/rtl/fuds_outbuf.sv
hw/rtl/form_urlencoded_stream_decoder.sv
tb/tb_top.sv
